>>> rtl/nmsc_pkg.sv
// shared types, character codes and lookup functions for the nmea sentence checker
package nmsc_pkg;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int TYPE_W   = 3;
   localparam int FIELD_W  = 5;
   localparam int FCNT_W   = 6;
   localparam int HDR_LEN  = 6;
   localparam int HDR_IDX_W = $clog2(HDR_LEN);

   localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
   localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
   localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
   localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
   localparam logic [BYTE_W-1:0] CH_N      = 8'h4E;
   localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
   localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
   localparam logic [BYTE_W-1:0] CH_S      = 8'h53;
   localparam logic [BYTE_W-1:0] CH_T      = 8'h54;
   localparam logic [BYTE_W-1:0] CH_V      = 8'h56;

   typedef enum logic [STATUS_W-1:0] {
      ST_NO_DOLLAR  = 3'd0,
      ST_CSUM_ERR   = 3'd1,
      ST_UNKNOWN    = 3'd2,
      ST_FEW_FIELDS = 3'd3,
      ST_USABLE     = 3'd4
   } status_type;

   typedef enum logic [TYPE_W-1:0] {
      SNT_NONE = 3'd0,
      SNT_GGA  = 3'd1,
      SNT_RMC  = 3'd2,
      SNT_VTG  = 3'd3,
      SNT_GSV  = 3'd4,
      SNT_GSA  = 3'd5
   } snt_type;

   typedef logic [HDR_LEN-1:0][BYTE_W-1:0] hdr_chars_type;

   typedef struct packed {
      snt_type kind;
      logic    gn;
   } hdr_info_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic logic [FCNT_W-1:0] min_fields(snt_type kind);
      logic [FCNT_W-1:0] m;
      unique case (kind)
         SNT_GGA: m = FCNT_W'(15);
         SNT_RMC: m = FCNT_W'(12);
         SNT_VTG: m = FCNT_W'(9);
         SNT_GSV: m = FCNT_W'(4);
         SNT_GSA: m = FCNT_W'(18);
         default: m = '0;
      endcase
      return m;
   endfunction

   function automatic hex_type hex_digit(logic [BYTE_W-1:0] b);
      hex_type h;
      h.valid = 1'b1;
      h.value = '0;
      priority if (b >= 8'h30 && b <= 8'h39) begin
         h.value = 4'(b - 8'h30);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.value = 4'(b - 8'h37);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.value = 4'(b - 8'h57);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

>>> rtl/nmsc_req_if.sv
// byte input channel of the nmea sentence checker
interface nmsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/nmsc_rsp_if.sv
// result channel of the nmea sentence checker
interface nmsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [2:0] sentence_type;
   logic       talker_gn;
   logic [4:0] field_count;
   logic [7:0] computed_checksum;
   logic [7:0] received_checksum;

   modport source (output valid, output status, output sentence_type, output talker_gn,
                   output field_count, output computed_checksum,
                   output received_checksum, input ready);
   modport sink   (input valid, input status, input sentence_type, input talker_gn,
                   input field_count, input computed_checksum,
                   input received_checksum, output ready);
endinterface

>>> rtl/nmsc_hdr_dec.sv
// header token decoder: talker and sentence type from the first six header bytes
module nmsc_hdr_dec
   import nmsc_pkg::*;
(
   input  hdr_chars_type hdr,
   output hdr_info_type  info
);

   logic talker_ok;

   assign talker_ok = (hdr[0] == CH_DOLLAR) && (hdr[1] == CH_G)
                      && ((hdr[2] == CH_N) || (hdr[2] == CH_P));

   always_comb begin
      info.kind = SNT_NONE;
      info.gn   = 1'b0;
      if (talker_ok) begin
         priority if (hdr[3] == CH_G && hdr[4] == CH_G && hdr[5] == CH_A) begin
            info.kind = SNT_GGA;
         end else if (hdr[3] == CH_R && hdr[4] == CH_M && hdr[5] == CH_C) begin
            info.kind = SNT_RMC;
         end else if (hdr[3] == CH_V && hdr[4] == CH_T && hdr[5] == CH_G) begin
            info.kind = SNT_VTG;
         end else if (hdr[3] == CH_G && hdr[4] == CH_S && hdr[5] == CH_V) begin
            info.kind = SNT_GSV;
         end else if (hdr[3] == CH_G && hdr[4] == CH_S && hdr[5] == CH_A) begin
            info.kind = SNT_GSA;
         end else begin
            info.kind = SNT_NONE;
         end
         info.gn = (info.kind != SNT_NONE) && (hdr[2] == CH_N);
      end
   end

endmodule

>>> rtl/nmea_sentence_checker.sv
// top level of the nmea sentence checker
// Takes one received byte per beat and gives one result beat per newline byte.
// Every byte updates the line state (checksum, star and hex digits, header
// bytes, field count) as it is taken, so a byte is accepted every cycle unless a newline stalls.
// A newline loads the result register from the state built up so far and
// clears the line; the result register lets further bytes in while it waits,
// and only a newline stalls when an earlier result has not been taken yet.
// A line that grows past LINE_BYTES-1 bytes is dropped with no result.
module nmea_sentence_checker
   import nmsc_pkg::*;
#(
   parameter int LINE_BYTES = 256,
   parameter int MAX_FIELDS = 24
) (
   input logic         clock,
   input logic         reset,
   nmsc_req_if.sink    req_bus,
   nmsc_rsp_if.source  rsp_bus
);

   localparam int LEN_W = $clog2(LINE_BYTES);
   localparam logic [LEN_W-1:0]  LEN_LAST = LEN_W'(LINE_BYTES - 1);
   localparam logic [LEN_W-1:0]  LEN_HDR  = LEN_W'(HDR_LEN);
   localparam logic [FCNT_W-1:0] FCNT_MAX = FCNT_W'(MAX_FIELDS);

   // line state
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic              star_ff, star_in;
   logic              hex_act_ff, hex_act_in;
   logic [BYTE_W-1:0] hex_val_ff, hex_val_in;
   logic              dollar_ff, dollar_in;
   hdr_chars_type     hdr_ff, hdr_in;
   logic              hdr_done_ff, hdr_done_in;
   logic [FCNT_W-1:0] fcnt_ff, fcnt_in;
   logic              in_field_ff, in_field_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   snt_type              kind_ff, kind_in;
   logic                 gn_ff, gn_in;
   logic [FIELD_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]    cx_ff, cx_in;
   logic [BYTE_W-1:0]    rx_ff, rx_in;

   logic [BYTE_W-1:0] rx_byte;
   logic              is_nl;
   logic              accept;
   logic              is_comma;
   hex_type           hex;
   hdr_info_type      hdr_info;
   logic [BYTE_W-1:0] rcv_sum;

   assign rx_byte  = req_bus.rx_byte;
   assign is_nl    = (rx_byte == CH_NL);
   assign is_comma = (rx_byte == CH_COMMA);
   assign req_bus.ready = !is_nl || !rsp_valid_ff || rsp_bus.ready;
   assign accept   = req_bus.valid && req_bus.ready;
   assign hex      = hex_digit(rx_byte);

   nmsc_hdr_dec u_hdr_dec (
      .hdr  (hdr_ff),
      .info (hdr_info)
   );

   // per byte line update
   always_comb begin
      len_in      = len_ff;
      xor_in      = xor_ff;
      star_in     = star_ff;
      hex_act_in  = hex_act_ff;
      hex_val_in  = hex_val_ff;
      dollar_in   = dollar_ff;
      hdr_in      = hdr_ff;
      hdr_done_in = hdr_done_ff;
      fcnt_in     = fcnt_ff;
      in_field_in = in_field_ff;
      if (accept) begin
         if (is_nl || (len_ff == LEN_LAST)) begin
            len_in      = '0;
            xor_in      = '0;
            star_in     = 1'b0;
            hex_act_in  = 1'b0;
            hex_val_in  = '0;
            dollar_in   = 1'b0;
            hdr_in      = '0;
            hdr_done_in = 1'b0;
            fcnt_in     = '0;
            in_field_in = 1'b0;
         end else begin
            if (len_ff == '0) begin
               dollar_in = (rx_byte == CH_DOLLAR);
            end
            if (!star_ff) begin
               if (rx_byte == CH_STAR) begin
                  star_in    = 1'b1;
                  hex_act_in = 1'b1;
                  hex_val_in = '0;
               end else if (len_ff != '0) begin
                  xor_in = xor_ff ^ rx_byte;
               end
            end else if (hex_act_ff) begin
               if (!hex.valid) begin
                  hex_act_in = 1'b0;
               end else begin
                  hex_val_in = {hex_val_ff[3:0], hex.value};
               end
            end
            if (!hdr_done_ff) begin
               if (is_comma) begin
                  hdr_done_in = 1'b1;
               end else if (len_ff < LEN_HDR) begin
                  hdr_in[len_ff[HDR_IDX_W-1:0]] = rx_byte;
               end else begin
                  hdr_in[0]   = '0;
                  hdr_done_in = 1'b1;
               end
            end
            if (is_comma) begin
               in_field_in = 1'b0;
            end else if (!in_field_ff) begin
               in_field_in = 1'b1;
               if (fcnt_ff < FCNT_MAX) begin
                  fcnt_in = fcnt_ff + FCNT_W'(1);
               end
            end
            len_in = len_ff + LEN_W'(1);
         end
      end
   end

   // result of the line ended by the current newline
   assign rcv_sum = star_ff ? hex_val_ff : '0;

   always_comb begin
      status_in = ST_NO_DOLLAR;
      kind_in   = SNT_NONE;
      gn_in     = 1'b0;
      count_in  = '0;
      cx_in     = '0;
      rx_in     = '0;
      if (dollar_ff) begin
         cx_in = xor_ff;
         rx_in = rcv_sum;
         priority if (!star_ff || (xor_ff != rcv_sum)) begin
            status_in = ST_CSUM_ERR;
         end else if (hdr_info.kind == SNT_NONE) begin
            status_in = ST_UNKNOWN;
            count_in  = fcnt_ff[FIELD_W-1:0];
         end else begin
            count_in  = fcnt_ff[FIELD_W-1:0];
            kind_in   = hdr_info.kind;
            gn_in     = hdr_info.gn;
            status_in = (fcnt_ff < min_fields(hdr_info.kind)) ? ST_FEW_FIELDS : ST_USABLE;
         end
      end
   end

   always_comb begin
      if (accept && is_nl) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         xor_ff       <= '0;
         star_ff      <= 1'b0;
         hex_act_ff   <= 1'b0;
         hex_val_ff   <= '0;
         dollar_ff    <= 1'b0;
         hdr_ff       <= '0;
         hdr_done_ff  <= 1'b0;
         fcnt_ff      <= '0;
         in_field_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         xor_ff       <= xor_in;
         star_ff      <= star_in;
         hex_act_ff   <= hex_act_in;
         hex_val_ff   <= hex_val_in;
         dollar_ff    <= dollar_in;
         hdr_ff       <= hdr_in;
         hdr_done_ff  <= hdr_done_in;
         fcnt_ff      <= fcnt_in;
         in_field_ff  <= in_field_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only when a newline beat is taken
   always_ff @(posedge clock) begin
      if (accept && is_nl) begin
         status_ff <= status_in;
         kind_ff   <= kind_in;
         gn_ff     <= gn_in;
         count_ff  <= count_in;
         cx_ff     <= cx_in;
         rx_ff     <= rx_in;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.status            = status_ff;
   assign rsp_bus.sentence_type     = kind_ff;
   assign rsp_bus.talker_gn         = gn_ff;
   assign rsp_bus.field_count       = count_ff;
   assign rsp_bus.computed_checksum = cx_ff;
   assign rsp_bus.received_checksum = rx_ff;

endmodule

>>> verif/tb.sv
// testbench for nmea_sentence_checker: byte lines in, checked one result beat per newline
`timescale 1ns / 1ps

module tb;
   import nmsc_pkg::*;

   localparam int LINE_CAP  = 256;
   localparam int TOKEN_CAP = 24;
   localparam int RAND_BYTES = 300;
   localparam int DRAIN = 16;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      status_type  status;
      snt_type     kind;
      logic        gn;
      logic [4:0]  fields;
      logic [7:0]  calc_sum;
      logic [7:0]  recv_sum;
   } line_result_type;

   typedef enum {SUM_NONE, SUM_UPPER, SUM_LOWER, SUM_BAD} sum_mode_type;

   typedef struct {
      string           text;
      sum_mode_type    mode;
      bit              typed;
      line_result_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nmsc_req_if req_ch ();
   nmsc_rsp_if rsp_ch ();

   nmea_sentence_checker #(
      .LINE_BYTES(LINE_CAP),
      .MAX_FIELDS(TOKEN_CAP)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_ch),
      .rsp_bus(rsp_ch)
   );

   always #5 clock = ~clock;

   // line state of the checker as predicted
   int unsigned line_len;
   logic [7:0]  run_xor;
   bit          star;
   bit          hex_on;
   logic [7:0]  hex_acc;
   bit          dollar_first;
   logic [7:0]  hdr[6];
   bit          hdr_done;
   int unsigned ntok;
   bit          in_tok;

   line_result_type verdicts[$];
   plan_row_type    plan[$];
   int              mismatches = 0;
   int              results_seen = 0;
   bit              tx_steady = 1'b0;
   bit              rx_steady = 1'b0;

   function automatic int nib(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
      if (v < 10) return 8'("0" + v);
      return lower ? 8'("a" + v - 10) : 8'("A" + v - 10);
   endfunction

   function automatic void clear_line();
      line_len = 0;
      run_xor = '0;
      star = 1'b0;
      hex_on = 1'b0;
      hex_acc = '0;
      dollar_first = 1'b0;
      foreach (hdr[i]) hdr[i] = '0;
      hdr_done = 1'b0;
      ntok = 0;
      in_tok = 1'b0;
   endfunction

   function automatic void absorb(logic [7:0] b);
      int d;
      int unsigned pos;
      pos = line_len;
      d = nib(b);
      if (pos == 0) dollar_first = (b == CH_DOLLAR);
      if (!star) begin
         if (b == CH_STAR) begin
            star = 1'b1;
            hex_on = 1'b1;
            hex_acc = '0;
         end else if (pos > 0) begin
            run_xor ^= b;
         end
      end else if (hex_on) begin
         if (d < 0) hex_on = 1'b0;
         else hex_acc = {hex_acc[3:0], 4'(d)};
      end
      if (!hdr_done) begin
         if (b == CH_COMMA) begin
            hdr_done = 1'b1;
         end else if (pos < 6) begin
            hdr[pos] = b;
         end else begin
            hdr[0] = '0;
            hdr_done = 1'b1;
         end
      end
      if (b == CH_COMMA) begin
         in_tok = 1'b0;
      end else if (!in_tok) begin
         in_tok = 1'b1;
         if (ntok < TOKEN_CAP) ntok++;
      end
      line_len = pos + 1;
   endfunction

   function automatic snt_type header_kind();
      if (hdr[0] != CH_DOLLAR || hdr[1] != CH_G || (hdr[2] != CH_N && hdr[2] != CH_P))
         return SNT_NONE;
      case ({hdr[3], hdr[4], hdr[5]})
         "GGA":   return SNT_GGA;
         "RMC":   return SNT_RMC;
         "VTG":   return SNT_VTG;
         "GSV":   return SNT_GSV;
         "GSA":   return SNT_GSA;
         default: return SNT_NONE;
      endcase
   endfunction

   function automatic int min_tokens(snt_type k);
      case (k)
         SNT_GGA: return 15;
         SNT_RMC: return 12;
         SNT_VTG: return 9;
         SNT_GSV: return 4;
         SNT_GSA: return 18;
         default: return 0;
      endcase
   endfunction

   // returns 1 when the byte closes a line, with the verdict in r
   function automatic bit classify_byte(logic [7:0] b, output line_result_type r);
      r = '0;
      r.status = ST_NO_DOLLAR;
      r.kind = SNT_NONE;
      if (b != CH_NL) begin
         if (line_len < LINE_CAP - 1) absorb(b);
         else clear_line();
         return 1'b0;
      end
      if (dollar_first) begin
         r.calc_sum = run_xor;
         r.recv_sum = star ? hex_acc : 8'd0;
         if (!star || r.calc_sum != r.recv_sum) begin
            r.status = ST_CSUM_ERR;
         end else begin
            r.fields = 5'(ntok);
            r.kind = header_kind();
            if (r.kind == SNT_NONE) begin
               r.status = ST_UNKNOWN;
            end else begin
               r.gn = (hdr[2] == CH_N);
               r.status = (int'(ntok) < min_tokens(r.kind)) ? ST_FEW_FIELDS : ST_USABLE;
            end
         end
      end
      clear_line();
      return 1'b1;
   endfunction

   function automatic int pick_idle(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ~hh in the text stands for a raw byte
   function automatic void text_bytes(input string s, ref byte_q_type q);
      int i;
      i = 0;
      while (i < s.len()) begin
         if (s[i] == "~") begin
            q.push_back({4'(nib(s[i+1])), 4'(nib(s[i+2]))});
            i += 3;
         end else begin
            q.push_back(s[i]);
            i++;
         end
      end
   endfunction

   function automatic void fill_sum(ref byte_q_type q, input sum_mode_type m);
      logic [7:0] x;
      bit lower;
      if (m == SUM_NONE) return;
      x = '0;
      for (int i = 1; i < q.size(); i++) x ^= q[i];
      if (m == SUM_BAD) x ^= 8'h5A;
      lower = (m == SUM_LOWER);
      q.push_back(CH_STAR);
      q.push_back(hex_char(x[7:4], lower));
      q.push_back(hex_char(x[3:0], lower));
   endfunction

   function automatic void add_row(string text, sum_mode_type mode, bit typed = 1'b0,
                                   line_result_type want = '0);
      plan_row_type row;
      row.text = text;
      row.mode = mode;
      row.typed = typed;
      row.want = want;
      plan.push_back(row);
   endfunction

   function automatic byte_q_type make_line();
      byte_q_type q;
      string field_set = "0123456789.-NSEWMKabcxyz";
      string kinds[5] = '{"GGA", "RMC", "VTG", "GSV", "GSA"};
      int mins[5] = '{15, 12, 9, 4, 18};
      int roll, pick, nf, len, k, idx;
      logic [7:0] x;
      bit lower;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         len = $urandom_range(250, 300);
         q.push_back(CH_DOLLAR);
         repeat (len) q.push_back(8'($urandom_range(11, 255)));
         q.push_back(CH_NL);
         return q;
      end
      if (roll < 14) begin
         len = $urandom_range(0, 40);
         repeat (len) q.push_back(8'($urandom()));
         if (len > 0 && $urandom_range(0, 1)) q[0] = CH_DOLLAR;
         q.push_back(CH_NL);
         return q;
      end
      q.push_back(CH_DOLLAR);
      q.push_back(CH_G);
      k = $urandom_range(0, 19);
      q.push_back(k == 0 ? 8'("L") : (k < 10 ? CH_N : CH_P));
      pick = $urandom_range(0, 4);
      if ($urandom_range(0, 19) == 0) begin
         repeat (3) q.push_back(8'($urandom_range(65, 90)));
      end else begin
         for (int j = 0; j < 3; j++) q.push_back(kinds[pick][j]);
      end
      k = $urandom_range(0, 9);
      if (k < 7) nf = mins[pick] - 3 + int'($urandom_range(0, 4));
      else if (k < 9) nf = $urandom_range(0, 30);
      else nf = 0;
      if (nf < 0) nf = 0;
      repeat (nf) begin
         q.push_back(CH_COMMA);
         len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
         repeat (len) q.push_back(field_set[$urandom_range(0, field_set.len() - 1)]);
      end
      x = '0;
      for (int i = 1; i < q.size(); i++) x ^= q[i];
      lower = $urandom_range(0, 1);
      k = $urandom_range(0, 99);
      if (k < 8) x ^= 8'($urandom_range(1, 255));
      if (k < 8 || k >= 12) begin
         q.push_back(CH_STAR);
         if (k >= 12 && k < 16) begin
            q.push_back(hex_char(x[3:0], lower));
         end else begin
            q.push_back(hex_char(x[7:4], lower));
            q.push_back(hex_char(x[3:0], lower));
            if (k >= 16 && k < 19) q.push_back(hex_char(4'($urandom()), lower));
         end
      end
      if ($urandom_range(0, 2) == 0) q.push_back(8'h0D);
      if (roll < 26) begin
         idx = $urandom_range(1, q.size() - 1);
         case ($urandom_range(0, 3))
            0: q.delete(0);
            1: q[idx] ^= 8'(1 << $urandom_range(0, 7));
            2: q = q[0:idx];
            default: q.insert(idx, CH_STAR);
         endcase
      end
      q.push_back(CH_NL);
      return q;
   endfunction

   task automatic flag_mismatch(string what, int got, int want);
      mismatches++;
      $display("tb: mismatch on %s, result %0d: got %0d want %0d",
               what, results_seen, got, want);
   endtask

   task automatic check_result();
      line_result_type w;
      results_seen++;
      if (verdicts.size() == 0) begin
         flag_mismatch("unexpected beat", rsp_ch.status, 0);
         return;
      end
      w = verdicts.pop_front();
      if (rsp_ch.status !== w.status) flag_mismatch("status", rsp_ch.status, w.status);
      if (rsp_ch.sentence_type !== w.kind)
         flag_mismatch("sentence_type", rsp_ch.sentence_type, w.kind);
      if (rsp_ch.talker_gn !== w.gn) flag_mismatch("talker_gn", rsp_ch.talker_gn, w.gn);
      if (rsp_ch.field_count !== w.fields)
         flag_mismatch("field_count", rsp_ch.field_count, w.fields);
      if (rsp_ch.computed_checksum !== w.calc_sum)
         flag_mismatch("computed_checksum", rsp_ch.computed_checksum, w.calc_sum);
      if (rsp_ch.received_checksum !== w.recv_sum)
         flag_mismatch("received_checksum", rsp_ch.received_checksum, w.recv_sum);
   endtask

   task automatic send_line(input byte_q_type q, input bit typed,
                            input line_result_type want);
      line_result_type got;
      int gap;
      if ($urandom_range(0, 9) == 0) tx_steady = !tx_steady;
      foreach (q[i]) begin
         req_ch.valid <= 1'b1;
         req_ch.rx_byte <= q[i];
         do @(posedge clock); while (!req_ch.ready);
         if (classify_byte(q[i], got)) verdicts.push_back(typed ? want : got);
         gap = pick_idle(tx_steady);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // result side: random stalls, checks every beat
   initial begin
      int hold;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_result();
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
            hold = pick_idle(rx_steady);
            if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
         end
      end
   end

   initial begin
      byte_q_type q, q2;
      line_result_type w;
      int rand_bytes;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      clear_line();
      rand_bytes = 0;

      w = '0;
      w.status = ST_NO_DOLLAR;
      w.kind = SNT_NONE;
      add_row("", SUM_NONE, 1'b1, w);
      add_row("GPGGA,1,2*00", SUM_NONE, 1'b1, w);
      w.status = ST_CSUM_ERR;
      add_row("$", SUM_NONE, 1'b1, w);
      add_row("$GNGGA,1,2,3,4,5,6,7,8,9,10,11,12,13,14", SUM_UPPER);
      add_row("$GPGGA,1,2,3,4,5,6,7,8,9,10,11,12,13", SUM_UPPER);
      add_row("$GPRMC,a,b,c,d,e,f,g,h,i,j,k", SUM_LOWER);
      add_row("$GNVTG,1,2,3,4,5,6,7,8", SUM_UPPER);
      add_row("$GPGSV,1,2,3", SUM_UPPER);
      add_row("$GNGSA,1,,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17", SUM_UPPER);
      add_row({"$GPGSA,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17,18,19,20,",
               "21,22,23,24,25,26,27,28,29,30"}, SUM_LOWER);
      add_row("$GPXYZ,1,2", SUM_UPPER);
      add_row("$GLGGA,1", SUM_UPPER);
      add_row("$GPGGAX,1,2", SUM_UPPER);
      add_row("$GPVTG,1,2,3,4,5,6,7,8", SUM_BAD);
      add_row("$GPGSV,1,2,3*1F3", SUM_NONE);
      add_row("$GPGSV,1*G1", SUM_NONE);
      add_row("$GPGSV,1* 1F", SUM_NONE);
      add_row("$GPGSV,1*0x1F", SUM_NONE);
      add_row("$GPGSV,1,2,3~00~FF~80~0D", SUM_UPPER);
      add_row("$*", SUM_NONE);
      add_row("$GPGSV,1,2*AB*CD", SUM_NONE);
      add_row("$,,,,*00", SUM_NONE);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         q.delete();
         text_bytes(plan[r].text, q);
         fill_sum(q, plan[r].mode);
         q.push_back(CH_NL);
         send_line(q, plan[r].typed, plan[r].want);
      end

      // a line of 254 bytes before the newline, which still gives a result
      q.delete();
      text_bytes("$GPGSV,1,2,", q);
      while (q.size() < LINE_CAP - 5) q.push_back("Z");
      fill_sum(q, SUM_UPPER);
      q.push_back(CH_NL);
      send_line(q, 1'b0, '0);

      // overflow, then a fresh sentence in the same stream
      q.delete();
      q.push_back(CH_DOLLAR);
      while (q.size() < LINE_CAP) q.push_back("Q");
      q2.delete();
      text_bytes("$GPGSV,1,2,3", q2);
      fill_sum(q2, SUM_LOWER);
      q = {q, q2};
      q.push_back(CH_NL);
      send_line(q, 1'b0, '0);

      // overflow with newline right after the dropped byte
      q.delete();
      q.push_back(CH_DOLLAR);
      while (q.size() < LINE_CAP) q.push_back("Q");
      q.push_back(CH_NL);
      w = '0;
      w.status = ST_NO_DOLLAR;
      w.kind = SNT_NONE;
      send_line(q, 1'b1, w);

      // hold off until every pending result has come out
      req_ch.valid <= 1'b0;
      while (verdicts.size() != 0) @(posedge clock);

      while (rand_bytes < RAND_BYTES) begin
         q = make_line();
         send_line(q, 1'b0, '0);
         rand_bytes += q.size();
      end
      req_ch.valid <= 1'b0;

      while (verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("tb: done, errors");
      $finish;
   end

endmodule
